@@ sv/gfba_pkg.sv @@
// Shared types, constants and helpers for the grouped free block allocator.
`default_nettype none

package gfba_pkg;

	// Geometry of the free list
	localparam int ZONES      = 1024;
	localparam int GROUP      = 15;
	localparam int BLK_W      = 10;
	localparam int CNT_W      = 11;
	localparam int FILL_W     = $clog2(GROUP + 1);
	localparam int SLOT_DEPTH = ZONES * GROUP;
	localparam int SLOT_W     = $clog2(SLOT_DEPTH);
	localparam int HDR_AW     = $clog2(ZONES);
	localparam int CFG_IDX_W  = 1;

	typedef logic [BLK_W-1:0]     blk_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [FILL_W-1:0]    fill_t;
	typedef logic [SLOT_W-1:0]    slot_addr_t;
	typedef logic [HDR_AW-1:0]    hdr_addr_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cnt_t  CNT_MAX  = {CNT_W{1'b1}};
	localparam fill_t FILL_MAX = FILL_W'(GROUP);

	// Commands
	localparam logic CMD_FREE  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FREE_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY      = 2'd2;
	localparam logic [1:0] ST_POP_RANGE  = 2'd3;

	// Configuration register indexes
	localparam cfg_idx_t REG_FIRST_ZONE = 1'b0;
	localparam cfg_idx_t REG_ZONE_COUNT = 1'b1;

	// Group header: fill count and link to the next group block
	typedef struct packed {
		fill_t fill;
		blk_t  link;
	} hdr_t;

	// Access request from the control logic to the stores
	typedef struct packed {
		logic       hdr_we;
		hdr_addr_t  hdr_addr;
		hdr_t       hdr_wdata;
		logic       slot_we;
		slot_addr_t slot_addr;
		blk_t       slot_wdata;
	} mem_req_t;

	// Flat slot address of entry f in the group held by block b
	function automatic slot_addr_t slot_addr(input blk_t b, input fill_t f);
		return SLOT_W'(int'(b) * GROUP + int'(f));
	endfunction

endpackage

`default_nettype wire

@@ sv/gfba_store.sv @@
// Group header memory and group slot memory, registered reads.
`default_nettype none

module gfba_store (
	input  wire logic            clk,
	input  wire gfba_pkg::mem_req_t req,
	output gfba_pkg::hdr_t       hdr_rdata,
	output gfba_pkg::blk_t       slot_rdata
);

	gfba_pkg::hdr_t hdr_mem  [gfba_pkg::ZONES];
	gfba_pkg::blk_t slot_mem [gfba_pkg::SLOT_DEPTH];

	// Header store: read-first, one port
	always_ff @(posedge clk) begin
		if (req.hdr_we) begin
			hdr_mem[req.hdr_addr] <= req.hdr_wdata;
		end
		hdr_rdata <= hdr_mem[req.hdr_addr];
	end

	// Slot store: read-first, one port
	always_ff @(posedge clk) begin
		if (req.slot_we) begin
			slot_mem[req.slot_addr] <= req.slot_wdata;
		end
		slot_rdata <= slot_mem[req.slot_addr];
	end

endmodule

`default_nettype wire

@@ sv/grouped_free_block_allocator.sv @@
// Top level of the grouped free block allocator: command sequencer and list head.
//
// A command is taken when start is high and busy is low. All frees, empty-list
// allocations and allocations handing out the head block end in S_HDR, updating
// the head group's header (fill count and link) read from the header memory as
// the command is taken. An allocation popping a number from the head group goes
// on to S_SLOT to wait on the slot memory read. The result is shown for one cycle
// with done high and cannot be held off; the next command may be given in that
// same cycle. The group memories are not cleared at reset: an entry is only ever
// read after the command that made its block a group head wrote it.
`default_nettype none

module grouped_free_block_allocator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      cmd,
	input  wire logic [9:0]                block_number,
	input  wire logic                      cfg_we,
	input  wire logic [gfba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [10:0]               cfg_data,
	output logic                           done,
	output logic [9:0]                     allocated_block,
	output logic [1:0]                     status,
	output logic [10:0]                    free_total
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HDR  = 2'd1;
	localparam logic [1:0] S_SLOT = 2'd2;

	logic [1:0]        state_q, state_d;
	logic              cmd_q;
	gfba_pkg::blk_t    blk_q;
	logic              blk_ok_q;
	gfba_pkg::blk_t    head_q, head_d;
	logic              present_q, present_d;
	gfba_pkg::cnt_t    count_q, count_d;
	gfba_pkg::blk_t    first_zone_q;
	gfba_pkg::cnt_t    zone_count_q;
	logic              done_q, done_d;
	gfba_pkg::blk_t    alloc_q, alloc_d;
	logic [1:0]        status_q, status_d;
	gfba_pkg::cnt_t    total_q;

	gfba_pkg::mem_req_t req;
	gfba_pkg::hdr_t     hdr_rdata;
	gfba_pkg::blk_t     slot_rdata;

	gfba_pkg::fill_t    fill_clamp, fill_dec;
	gfba_pkg::blk_t     pop_blk;
	logic               pop_now;
	logic               accept;

	function automatic logic in_zone(input gfba_pkg::blk_t b, input gfba_pkg::blk_t lo,
			input gfba_pkg::cnt_t hi);
		return (b >= lo) && (gfba_pkg::CNT_W'(b) < hi);
	endfunction

	gfba_store u_store (
		.clk        (clk),
		.req        (req),
		.hdr_rdata  (hdr_rdata),
		.slot_rdata (slot_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_zone_q <= '0;
			zone_count_q <= gfba_pkg::CNT_W'(gfba_pkg::ZONES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gfba_pkg::REG_FIRST_ZONE: first_zone_q <= cfg_data[gfba_pkg::BLK_W-1:0];
				gfba_pkg::REG_ZONE_COUNT: zone_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pop helpers: clamp a fill beyond the group size, and pick the popped number
	assign fill_clamp = (hdr_rdata.fill > gfba_pkg::FILL_MAX) ? gfba_pkg::FILL_MAX
			: hdr_rdata.fill;
	assign fill_dec   = fill_clamp - 1'b1;
	assign pop_blk    = (state_q == S_SLOT) ? slot_rdata : head_q;

	// Sequencer, list head update and memory requests
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		present_d = present_q;
		count_d   = count_q;
		done_d    = 1'b0;
		alloc_d   = '0;
		status_d  = gfba_pkg::ST_OK;
		pop_now   = 1'b0;

		req.hdr_we     = 1'b0;
		req.hdr_addr   = gfba_pkg::HDR_AW'(head_q);
		req.hdr_wdata  = hdr_rdata;
		req.slot_we    = 1'b0;
		req.slot_addr  = gfba_pkg::slot_addr(head_q, fill_dec);
		req.slot_wdata = blk_q;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_HDR;
				end
			end
			S_HDR: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				if (cmd_q == gfba_pkg::CMD_FREE) begin
					if (!blk_ok_q) begin
						status_d = gfba_pkg::ST_FREE_RANGE;
					end else begin
						if (!present_q || hdr_rdata.fill >= gfba_pkg::FILL_MAX) begin
							// freed block opens a new group in front of the old head
							req.hdr_we         = 1'b1;
							req.hdr_addr       = gfba_pkg::HDR_AW'(blk_q);
							req.hdr_wdata.fill = '0;
							req.hdr_wdata.link = present_q ? head_q : '0;
							head_d             = blk_q;
							present_d          = 1'b1;
						end else begin
							// push into the head group
							req.slot_we        = 1'b1;
							req.slot_addr      = gfba_pkg::slot_addr(head_q, hdr_rdata.fill);
							req.hdr_we         = 1'b1;
							req.hdr_wdata.fill = hdr_rdata.fill + 1'b1;
						end
						if (count_q != gfba_pkg::CNT_MAX) begin
							count_d = count_q + 1'b1;
						end
					end
				end else begin
					if (!present_q) begin
						status_d = gfba_pkg::ST_EMPTY;
					end else if (hdr_rdata.fill != '0) begin
						// pop a slot: update fill now, number arrives next cycle
						req.hdr_we         = 1'b1;
						req.hdr_wdata.fill = fill_dec;
						done_d             = 1'b0;
						state_d            = S_SLOT;
					end else begin
						// hand out the head block itself and follow the link
						head_d    = hdr_rdata.link;
						present_d = (hdr_rdata.link != '0);
						pop_now   = 1'b1;
					end
				end
			end
			S_SLOT: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				pop_now = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Range check on the handed-out number
		if (pop_now) begin
			if (in_zone(pop_blk, first_zone_q, zone_count_q)) begin
				alloc_d = pop_blk;
				if (count_q != '0) begin
					count_d = count_q - 1'b1;
				end
			end else begin
				status_d = gfba_pkg::ST_POP_RANGE;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			present_q <= 1'b0;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			present_q <= present_d;
			count_q   <= count_d;
			done_q    <= done_d;
		end
	end

	// Command capture and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			blk_q    <= block_number;
			blk_ok_q <= in_zone(block_number, first_zone_q, zone_count_q);
		end
		if (done_d) begin
			alloc_q  <= alloc_d;
			status_q <= status_d;
			total_q  <= count_d;
		end
	end

	assign done            = done_q;
	assign allocated_block = alloc_q;
	assign status          = status_q;
	assign free_total      = total_q;

endmodule

`default_nettype wire

@@ sv/gfba_checker.sv @@
// Port-level checks for the grouped free block allocator, bound to the top level.
`default_nettype none

module gfba_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic                      cmd,
	input wire logic [9:0]                block_number,
	input wire logic                      cfg_we,
	input wire logic [gfba_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [10:0]               cfg_data,
	input wire logic                      done,
	input wire logic [9:0]                allocated_block,
	input wire logic [1:0]                status,
	input wire logic [10:0]               free_total
);

	// A taken command keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command taken but block not busy");

	// A result never shows in the cycle right after a command is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe too early");

	// A result follows a busy cycle and frees the command side
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside a finished command");

	// Any failing status hands out no block
	a_fail_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != gfba_pkg::ST_OK)) |-> (allocated_block == '0))
		else $error("block handed out with failing status");

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (.*);

`default_nettype wire

@@ tb/sv/tb_grouped_free_block_allocator.sv @@
// Self-checking testbench for the grouped free block allocator: directed and random commands.
module tb_grouped_free_block_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	// One expected result of a command
	typedef struct {
		gfba_pkg::blk_t block;
		logic [1:0]     status;
		gfba_pkg::cnt_t total;
	} outcome_t;

	// Tracks the free list as the block should hold it and checks every result
	class FreeListTracker;
		gfba_pkg::blk_t  first_zone;
		gfba_pkg::cnt_t  zone_limit;
		gfba_pkg::blk_t  head;
		bit              head_valid;
		gfba_pkg::cnt_t  free_count;
		gfba_pkg::fill_t fill_mem[gfba_pkg::ZONES];
		gfba_pkg::blk_t  link_mem[gfba_pkg::ZONES];
		gfba_pkg::blk_t  slot_mem[gfba_pkg::SLOT_DEPTH];
		outcome_t        awaited[$];
		int              failures;

		function new();
			first_zone = '0;
			zone_limit = gfba_pkg::cnt_t'(gfba_pkg::ZONES);
			head       = '0;
			head_valid = 1'b0;
			free_count = '0;
			failures   = 0;
		endfunction

		function bit in_zone(gfba_pkg::blk_t b);
			return b >= first_zone && gfba_pkg::cnt_t'(b) < zone_limit;
		endfunction

		function int slot_of(gfba_pkg::blk_t b, int f);
			return int'(b) * gfba_pkg::GROUP + f;
		endfunction

		function void set_register(gfba_pkg::cfg_idx_t idx, gfba_pkg::cnt_t data);
			if (idx == gfba_pkg::REG_FIRST_ZONE)
				first_zone = data[gfba_pkg::BLK_W-1:0];
			else
				zone_limit = data;
		endfunction

		// Apply one accepted command to the list and queue its result
		function void note_command(logic c, gfba_pkg::blk_t b);
			outcome_t       r;
			int             f;
			gfba_pkg::blk_t j;
			r.block  = '0;
			r.status = gfba_pkg::ST_OK;
			if (c == gfba_pkg::CMD_FREE) begin
				if (!in_zone(b)) begin
					r.status = gfba_pkg::ST_FREE_RANGE;
				end else begin
					f = head_valid ? int'(fill_mem[head]) : 0;
					// no head or a full head group: freed block opens a new group
					if (!head_valid || f >= gfba_pkg::GROUP) begin
						fill_mem[b] = '0;
						link_mem[b] = head_valid ? head : '0;
						head        = b;
						head_valid  = 1'b1;
					end else begin
						slot_mem[slot_of(head, f)] = b;
						fill_mem[head] = gfba_pkg::fill_t'(f + 1);
					end
					if (free_count != gfba_pkg::CNT_MAX)
						free_count++;
				end
			end else if (!head_valid) begin
				r.status = gfba_pkg::ST_EMPTY;
			end else begin
				f = int'(fill_mem[head]);
				if (f > 0) begin
					if (f > gfba_pkg::GROUP)
						f = gfba_pkg::GROUP;
					f--;
					fill_mem[head] = gfba_pkg::fill_t'(f);
					j = slot_mem[slot_of(head, f)];
				end else begin
					// empty group: hand out the head itself, a zero link ends the chain
					j          = head;
					head       = link_mem[j];
					head_valid = head != '0;
				end
				if (!in_zone(j)) begin
					r.status = gfba_pkg::ST_POP_RANGE;
				end else begin
					r.block = j;
					if (free_count != '0)
						free_count--;
				end
			end
			r.total = free_count;
			awaited.push_back(r);
		endfunction

		function void check_result(gfba_pkg::blk_t a, logic [1:0] s, gfba_pkg::cnt_t t);
			outcome_t e;
			if (awaited.size() == 0) begin
				$error("result with no transaction outstanding: block %0d status %0d total %0d",
					a, s, t);
				failures++;
				return;
			end
			e = awaited.pop_front();
			if (a !== e.block) begin
				$error("allocated_block expected %0d actual %0d", e.block, a);
				failures++;
			end
			if (s !== e.status) begin
				$error("status expected %0d actual %0d", e.status, s);
				failures++;
			end
			if (t !== e.total) begin
				$error("free_total expected %0d actual %0d", e.total, t);
				failures++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               cmd = gfba_pkg::CMD_FREE;
	gfba_pkg::blk_t     block_number = '0;
	logic               cfg_we = 1'b0;
	gfba_pkg::cfg_idx_t cfg_index = gfba_pkg::REG_FIRST_ZONE;
	gfba_pkg::cnt_t     cfg_data = '0;
	logic               busy;
	logic               done;
	gfba_pkg::blk_t     allocated_block;
	logic [1:0]         status;
	gfba_pkg::cnt_t     free_total;

	FreeListTracker board = new();
	int idle_pct = 35;

	grouped_free_block_allocator u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.block_number    (block_number),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.allocated_block (allocated_block),
		.status          (status),
		.free_total      (free_total)
	);

	always #5 clk = ~clk;

	// Results cannot be held off: take each one at the edge that ends its cycle
	always @(posedge clk) begin
		if (done === 1'b1)
			board.check_result(allocated_block, status, free_total);
	end

	initial begin
		#5_000_000;
		$display("grouped_free_block_allocator verification failed");
		$finish;
	end

	// Present a command and hold it until the block takes it
	task automatic send_command(input logic c, input gfba_pkg::blk_t b);
		start        <= 1'b1;
		cmd          <= c;
		block_number <= b;
		do @(posedge clk); while (busy !== 1'b0);
		board.note_command(c, b);
	endtask

	task automatic idle_gap();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// Hold off until every outstanding result has come back
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (board.pending() != 0 || busy !== 1'b0);
	endtask

	task automatic write_reg(input gfba_pkg::cfg_idx_t idx, input gfba_pkg::cnt_t data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		board.set_register(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_zone(input int lo, input int limit);
		wait_idle();
		write_reg(gfba_pkg::REG_FIRST_ZONE, gfba_pkg::cnt_t'(lo));
		write_reg(gfba_pkg::REG_ZONE_COUNT, gfba_pkg::cnt_t'(limit));
	endtask

	// Mostly in-zone block numbers, the rest anywhere in the field
	function automatic gfba_pkg::blk_t pick_block(input int in_pct);
		int lo;
		int hi;
		lo = int'(board.first_zone);
		hi = int'(board.zone_limit) - 1;
		if (hi > gfba_pkg::ZONES - 1)
			hi = gfba_pkg::ZONES - 1;
		if (lo <= hi && $urandom_range(99) < in_pct)
			return gfba_pkg::blk_t'($urandom_range(hi, lo));
		return gfba_pkg::blk_t'($urandom_range(gfba_pkg::ZONES - 1));
	endfunction

	task automatic run_random(input int count, input int alloc_pct, input int in_pct);
		logic c;
		for (int i = 0; i < count; i++) begin
			c = ($urandom_range(99) < alloc_pct) ? gfba_pkg::CMD_ALLOC : gfba_pkg::CMD_FREE;
			send_command(c, pick_block(in_pct));
			idle_gap();
		end
	endtask

	initial begin
		gfba_pkg::blk_t fill_vals[15] = '{10'd0, 10'd1, 10'd2, 10'd4, 10'd8, 10'd16, 10'd32,
			10'd64, 10'd128, 10'd256, 10'd512, 10'd341, 10'd682, 10'd1022, 10'd1000};
		int lo;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, first head, full group, new head, pops
		send_command(gfba_pkg::CMD_ALLOC, 10'd1023);
		send_command(gfba_pkg::CMD_FREE, 10'd1023);
		foreach (fill_vals[i])
			send_command(gfba_pkg::CMD_FREE, fill_vals[i]);
		send_command(gfba_pkg::CMD_FREE, 10'd777);
		send_command(gfba_pkg::CMD_ALLOC, 10'd0);
		send_command(gfba_pkg::CMD_ALLOC, 10'd0);

		// Raise the zone floor: popped numbers below it are refused
		set_zone(512, 1024);
		send_command(gfba_pkg::CMD_ALLOC, 10'd0);
		send_command(gfba_pkg::CMD_ALLOC, 10'd0);
		send_command(gfba_pkg::CMD_ALLOC, 10'd0);
		send_command(gfba_pkg::CMD_FREE, 10'd3);

		// Single valid block
		set_zone(0, 1);
		send_command(gfba_pkg::CMD_FREE, 10'd1);
		send_command(gfba_pkg::CMD_FREE, 10'd0);

		// Fill several groups with frees, then drain the list past empty
		set_zone(0, 1024);
		run_random(150, 0, 100);
		wait_idle();
		run_random(170, 100, 100);

		// Random phases over several zone settings
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_zone(0, 1024);
				1: set_zone(1023, 1024);
				2: set_zone(0, 1);
				3: set_zone(1000, 24);
				4: set_zone(0, 1024);
				default: begin
					lo = $urandom_range(600);
					set_zone(lo, $urandom_range(1024, lo + 1));
				end
			endcase
			idle_pct = (p == 4) ? 0 : 35;
			run_random(60, $urandom_range(70, 30), 85);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (board.failures == 0)
			$display("grouped_free_block_allocator verification clean");
		else
			$display("grouped_free_block_allocator verification failed");
		$finish;
	end

endmodule
